[rtl/asc_pkg.sv]
// Shared types and constants for the adaptive step size controller.
// Used by asc_ctrl, asc_dp and adaptive_step_size_controller; no dependencies.
`default_nettype none
package asc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int STEP_BITS   = 32;
  localparam int OUT_BITS    = STEP_BITS + 2;
  localparam int RUN_BITS    = 8;
  localparam int OSC_BITS    = 16;
  localparam int NUM_BITS    = 2 * FRAC_BITS + 1;
  localparam int DIV_STEPS   = NUM_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
  localparam int PADDR_BITS  = 5;
  localparam int PDATA_BITS  = 32;
  localparam int IDX_BITS    = PADDR_BITS - 2;

  localparam logic [STEP_BITS:0] ONE_FIX =
    {{(STEP_BITS - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [NUM_BITS-1:0] NUM_INIT = {1'b1, {(2 * FRAC_BITS){1'b0}}};
  localparam logic [STEP_BITS-1:0] RESET_STEP = ONE_FIX[STEP_BITS-1:0];
  localparam logic [STEP_BITS-1:0] RESET_LARGEST = '1;
  localparam logic [STEP_BITS-1:0] RESET_SMALLEST = STEP_BITS'(1);
  localparam logic [RUN_BITS-1:0] RESET_RUN_LEN = RUN_BITS'(3);
  localparam logic [RUN_BITS-1:0] RUN_MAX = '1;
  localparam logic [OSC_BITS-1:0] OSC_MAX = '1;

  typedef enum logic [IDX_BITS-1:0] {
    REG_INITIAL_STEP  = 3'd0,
    REG_RUN_LENGTH    = 3'd1,
    REG_SMALLEST_STEP = 3'd2,
    REG_LARGEST_STEP  = 3'd3,
    REG_RELATIVE_MODE = 3'd4
  } asc_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } asc_state_e;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic push;
  } asc_cmd_t;

  typedef struct packed {
    logic need_div;
  } asc_sts_t;

  typedef struct packed {
    logic [RUN_BITS-1:0]  run_length_to_grow;
    logic [STEP_BITS-1:0] smallest_step;
    logic [STEP_BITS-1:0] largest_step;
    logic                 relative_mode;
  } asc_cfg_t;

endpackage
`default_nettype wire

[rtl/asc_ctrl.sv]
// Sequencer for the step size controller: input/output handshakes and divide count.
// Depends on asc_pkg.
`default_nettype none
module asc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire asc_pkg::asc_sts_t sts_i,
  output asc_pkg::asc_cmd_t     cmd_o
);

  asc_pkg::asc_state_e                state_q, state_d;
  logic [asc_pkg::DIV_CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                               out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asc_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      asc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = asc_pkg::DIV_CNT_BITS'(asc_pkg::DIV_STEPS - 1);
          state_d      = sts_i.need_div ? asc_pkg::ST_DIV : asc_pkg::ST_PUSH;
        end
      end
      asc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - asc_pkg::DIV_CNT_BITS'(1);
        if (cnt_q == '0) begin
          state_d = asc_pkg::ST_PUSH;
        end
      end
      asc_pkg::ST_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = asc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = asc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[rtl/asc_dp.sv]
// Datapath: step size state update, restoring reciprocal divider, result registers.
// Depends on asc_pkg.
`default_nettype none
module asc_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire asc_pkg::asc_cmd_t             cmd_i,
  output asc_pkg::asc_sts_t                  sts_o,
  input  wire asc_pkg::asc_cfg_t             cfg_i,
  input  wire logic                          restart_i,
  input  wire logic [asc_pkg::STEP_BITS-1:0] restart_step_i,
  input  wire logic                          direction_up_i,
  output logic signed [asc_pkg::OUT_BITS-1:0] step_value_o,
  output logic [asc_pkg::STEP_BITS-1:0]      current_step_o,
  output logic [asc_pkg::OSC_BITS-1:0]       oscillation_count_o
);

  logic [asc_pkg::STEP_BITS-1:0] step_q, step_d;
  logic [asc_pkg::RUN_BITS-1:0]  run_q, run_d;
  logic                          last_dir_q, last_dir_d;
  logic [asc_pkg::OSC_BITS-1:0]  osc_q, osc_d;

  logic [asc_pkg::OUT_BITS-1:0]  res_q;
  logic                          div_sel_q;
  logic [asc_pkg::STEP_BITS:0]   divisor_q;
  logic [asc_pkg::STEP_BITS:0]   rem_q;
  logic [asc_pkg::NUM_BITS-1:0]  quo_q;

  logic [asc_pkg::OUT_BITS-1:0]  step_value_q;
  logic [asc_pkg::STEP_BITS-1:0] current_step_q;
  logic [asc_pkg::OSC_BITS-1:0]  osc_out_q;

  logic                          same_dir;
  logic                          reversal;
  logic                          at_min;
  logic [asc_pkg::RUN_BITS-1:0]  run_new;
  logic [asc_pkg::STEP_BITS-1:0] step_half;
  logic [asc_pkg::STEP_BITS:0]   step_dbl;
  logic [asc_pkg::STEP_BITS-1:0] dbl_sat;
  logic [asc_pkg::STEP_BITS-1:0] dbl_clamp;
  logic [asc_pkg::STEP_BITS:0]   factor_sum;
  logic [asc_pkg::OUT_BITS-1:0]  res_new;
  logic [asc_pkg::STEP_BITS+1:0] trial;
  logic [asc_pkg::STEP_BITS+1:0] trial_diff;
  logic                          q_bit;

  always_comb begin
    same_dir  = (direction_up_i == last_dir_q);
    reversal  = !same_dir && (run_q != '0);
    if (!same_dir) begin
      run_new = asc_pkg::RUN_BITS'(1);
    end else if (run_q == asc_pkg::RUN_MAX) begin
      run_new = run_q;
    end else begin
      run_new = run_q + asc_pkg::RUN_BITS'(1);
    end
    step_half = step_q >> 1;
    step_dbl  = {step_q, 1'b0};
    dbl_sat   = step_dbl[asc_pkg::STEP_BITS] ? '1 : step_dbl[asc_pkg::STEP_BITS-1:0];
    dbl_clamp = (dbl_sat > cfg_i.largest_step) ? cfg_i.largest_step : dbl_sat;

    at_min = 1'b0;
    step_d = step_q;
    run_d  = run_new;
    if (reversal) begin
      if (step_q == cfg_i.smallest_step) begin
        at_min = 1'b1;
      end else begin
        step_d = (step_half < cfg_i.smallest_step) ? cfg_i.smallest_step : step_half;
      end
    end else if ((run_new >= cfg_i.run_length_to_grow) &&
                 (step_q < cfg_i.largest_step)) begin
      step_d = dbl_clamp;
      run_d  = run_new >> 1;
    end

    if (!at_min) begin
      osc_d = '0;
    end else if (osc_q == asc_pkg::OSC_MAX) begin
      osc_d = osc_q;
    end else begin
      osc_d = osc_q + asc_pkg::OSC_BITS'(1);
    end
    last_dir_d = direction_up_i;

    factor_sum = {1'b0, step_d} + asc_pkg::ONE_FIX;
    if (cfg_i.relative_mode) begin
      res_new = {1'b0, factor_sum};
    end else if (direction_up_i) begin
      res_new = {2'b00, step_d};
    end else begin
      res_new = asc_pkg::OUT_BITS'(0) - {2'b00, step_d};
    end
  end

  always_comb begin
    trial      = {rem_q, quo_q[asc_pkg::NUM_BITS-1]};
    trial_diff = trial - {1'b0, divisor_q};
    q_bit      = (trial >= {1'b0, divisor_q});
  end

  assign sts_o.need_div = cfg_i.relative_mode && !direction_up_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= asc_pkg::RESET_STEP;
      run_q      <= '0;
      last_dir_q <= 1'b1;
      osc_q      <= '0;
    end else if (restart_i) begin
      step_q     <= restart_step_i;
      run_q      <= '0;
      last_dir_q <= 1'b1;
      osc_q      <= '0;
    end else if (cmd_i.accept) begin
      step_q     <= step_d;
      run_q      <= run_d;
      last_dir_q <= last_dir_d;
      osc_q      <= osc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_q     <= res_new;
      div_sel_q <= sts_o.need_div;
      divisor_q <= factor_sum;
      rem_q     <= '0;
      quo_q     <= asc_pkg::NUM_INIT;
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? trial_diff[asc_pkg::STEP_BITS:0] : trial[asc_pkg::STEP_BITS:0];
      quo_q <= {quo_q[asc_pkg::NUM_BITS-2:0], q_bit};
    end
    if (cmd_i.push) begin
      step_value_q   <= div_sel_q ?
        {{(asc_pkg::OUT_BITS - asc_pkg::FRAC_BITS - 1){1'b0}}, quo_q[asc_pkg::FRAC_BITS:0]} :
        res_q;
      current_step_q <= step_q;
      osc_out_q      <= osc_q;
    end
  end

  assign step_value_o        = step_value_q;
  assign current_step_o      = current_step_q;
  assign oscillation_count_o = osc_out_q;

endmodule
`default_nettype wire

[rtl/adaptive_step_size_controller.sv]
// Top level: configuration registers on the APB port, sequencer and datapath.
// Depends on asc_pkg, asc_ctrl and asc_dp.
//
// Each transfer on the input channel carries one direction bit and yields one
// result transfer. In absolute mode, and in relative mode going up, the input
// transfer moves the sequencer from idle to the push state, and the push loads
// the result into the output register. In relative mode going down the factor
// 1/(1+step) comes from a restoring divider that retires one quotient bit per
// cycle over 33 dividend bits in the divide state, before the push. One item
// is in flight at a time; the next input is taken once the current result sits
// in the output register, even if it has not yet been taken, and a new result
// waits for the output register to empty. Registers must be written only while
// the block is idle; the block itself does not enforce this. Writing
// initial_step restarts the step size, run and oscillation state.
`default_nettype none
module adaptive_step_size_controller (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [asc_pkg::PADDR_BITS-1:0]    paddr,
  input  wire logic [asc_pkg::PDATA_BITS-1:0]    pwdata,
  output logic [asc_pkg::PDATA_BITS-1:0]         prdata,
  output logic                                   pready,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              direction_up_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [asc_pkg::OUT_BITS-1:0]    step_value_o,
  output logic [asc_pkg::STEP_BITS-1:0]          current_step_o,
  output logic [asc_pkg::OSC_BITS-1:0]           oscillation_count_o
);

  logic [asc_pkg::STEP_BITS-1:0] initial_step_q;
  logic [asc_pkg::RUN_BITS-1:0]  run_len_q;
  logic [asc_pkg::STEP_BITS-1:0] smallest_q;
  logic [asc_pkg::STEP_BITS-1:0] largest_q;
  logic                          relative_q;

  logic                          wr_en;
  logic [asc_pkg::IDX_BITS-1:0]  reg_idx;
  logic                          restart;
  asc_pkg::asc_cfg_t             cfg;
  asc_pkg::asc_cmd_t             cmd;
  asc_pkg::asc_sts_t             sts;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[asc_pkg::PADDR_BITS-1:2];
  assign restart = wr_en && (reg_idx == asc_pkg::REG_INITIAL_STEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_step_q <= asc_pkg::RESET_STEP;
      run_len_q      <= asc_pkg::RESET_RUN_LEN;
      smallest_q     <= asc_pkg::RESET_SMALLEST;
      largest_q      <= asc_pkg::RESET_LARGEST;
      relative_q     <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        asc_pkg::REG_INITIAL_STEP:  initial_step_q <= pwdata[asc_pkg::STEP_BITS-1:0];
        asc_pkg::REG_RUN_LENGTH:    run_len_q      <= pwdata[asc_pkg::RUN_BITS-1:0];
        asc_pkg::REG_SMALLEST_STEP: smallest_q     <= pwdata[asc_pkg::STEP_BITS-1:0];
        asc_pkg::REG_LARGEST_STEP:  largest_q      <= pwdata[asc_pkg::STEP_BITS-1:0];
        asc_pkg::REG_RELATIVE_MODE: relative_q     <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      asc_pkg::REG_INITIAL_STEP:  prdata = asc_pkg::PDATA_BITS'(initial_step_q);
      asc_pkg::REG_RUN_LENGTH:    prdata = asc_pkg::PDATA_BITS'(run_len_q);
      asc_pkg::REG_SMALLEST_STEP: prdata = asc_pkg::PDATA_BITS'(smallest_q);
      asc_pkg::REG_LARGEST_STEP:  prdata = asc_pkg::PDATA_BITS'(largest_q);
      asc_pkg::REG_RELATIVE_MODE: prdata = asc_pkg::PDATA_BITS'(relative_q);
      default:                    prdata = '0;
    endcase
  end

  assign cfg.run_length_to_grow = run_len_q;
  assign cfg.smallest_step      = smallest_q;
  assign cfg.largest_step       = largest_q;
  assign cfg.relative_mode      = relative_q;

  asc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  asc_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_i               (cfg),
    .restart_i           (restart),
    .restart_step_i      (pwdata[asc_pkg::STEP_BITS-1:0]),
    .direction_up_i      (direction_up_i),
    .step_value_o        (step_value_o),
    .current_step_o      (current_step_o),
    .oscillation_count_o (oscillation_count_o)
  );

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  a_push_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |=> out_valid_o)
    else $error("result push did not raise out_valid_o");

  a_valid_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.push))
    else $error("out_valid_o rose without a result push");

  a_no_ready_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !in_ready_o && !cmd.push)
    else $error("input ready or push during divide");
`endif

endmodule
`default_nettype wire
